// ===== rtl/core/tno_pkg.sv =====
// ----------------------------------------------------------------------------
// Telnet option negotiator package
// Shared types and protocol constants for the front parser and back emitter.
// ----------------------------------------------------------------------------
package tno_pkg;

	localparam logic [7:0] IAC  = 8'd255;
	localparam logic [7:0] SE   = 8'd240;
	localparam logic [7:0] GA   = 8'd249;
	localparam logic [7:0] SB   = 8'd250;
	localparam logic [7:0] WILL = 8'd251;
	localparam logic [7:0] WONT = 8'd252;
	localparam logic [7:0] DO   = 8'd253;
	localparam logic [7:0] DONT = 8'd254;

	localparam logic [7:0] OPT_TTYPE = 8'd24;
	localparam logic [7:0] OPT_NAWS  = 8'd31;
	localparam logic [7:0] OPT_SPEED = 8'd32;
	localparam logic [7:0] OPT_ENV   = 8'd39;

	localparam logic [1:0] MODE_RX    = 2'd0;
	localparam logic [1:0] MODE_TX    = 2'd1;
	localparam logic [1:0] MODE_NAWS  = 2'd2;

	localparam int SPEED_LEN = 11;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_CMD  = 2'd1,
		PH_OPT  = 2'd2,
		PH_SUB  = 2'd3
	} phase_t;

	// Kind of work handed from the front to the back.
	typedef enum logic [2:0] {
		JOB_APP    = 3'd0,
		JOB_LINK   = 3'd1,
		JOB_ANSWER = 3'd2,
		JOB_SUB    = 3'd3,
		JOB_NAWS   = 3'd4
	} job_kind_t;

	typedef struct packed {
		job_kind_t   kind;
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [31:0] wh;
	} job_t;

	typedef enum logic [2:0] {
		EP_HEAD  = 3'd0,
		EP_NAME  = 3'd1,
		EP_SPEED = 3'd2,
		EP_TAIL  = 3'd3,
		EP_NAWS  = 3'd4
	} emit_phase_t;

	function automatic logic [7:0] speed_byte(input logic [3:0] i);
		logic [7:0] r;
		case (i)
			4'd0, 4'd6: r = 8'h33;
			4'd1, 4'd7: r = 8'h38;
			4'd2, 4'd8: r = 8'h34;
			4'd5:       r = 8'h2C;
			default:    r = 8'h30;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/tno_front.sv =====
// ----------------------------------------------------------------------------
// Telnet option negotiator front end
// Parses received bytes, passes outbound and window size requests on, and turns every request into at most one job.
// ----------------------------------------------------------------------------
module tno_front import tno_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [1:0]  mode,
	input  logic [7:0]  in_byte,
	input  logic [15:0] window_width,
	input  logic [15:0] window_height,
	output logic        job_valid,
	output job_t        job
);

	phase_t     phase_q;
	logic [7:0] cmd_q;
	logic [7:0] opt_q;
	logic [2:0] pos_q;
	logic [7:0] prev_q;
	logic       ok_q;

	phase_t     phase_d;
	logic [7:0] cmd_d;
	logic [7:0] opt_d;
	logic [2:0] pos_d;
	logic [7:0] prev_d;
	logic       ok_d;

	always_comb begin
		phase_d   = phase_q;
		cmd_d     = cmd_q;
		opt_d     = opt_q;
		pos_d     = pos_q;
		prev_d    = prev_q;
		ok_d      = ok_q;
		job_valid = 1'b0;
		job.kind  = JOB_APP;
		job.b0    = in_byte;
		job.b1    = cmd_q;
		job.wh    = {window_width, window_height};
		if (in_valid) begin
			case (mode)
				MODE_TX: begin
					job_valid = 1'b1;
					job.kind  = JOB_LINK;
				end
				MODE_NAWS: begin
					job_valid = 1'b1;
					job.kind  = JOB_NAWS;
				end
				MODE_RX: begin
					case (phase_q)
						PH_IDLE: begin
							if (in_byte == IAC) begin
								phase_d = PH_CMD;
							end else begin
								job_valid = 1'b1;
							end
						end
						PH_CMD: begin
							phase_d = PH_IDLE;
							if (in_byte == IAC) begin
								job_valid = 1'b1;
							end else if (in_byte >= WILL) begin
								cmd_d   = in_byte;
								phase_d = PH_OPT;
							end else if (in_byte == SB) begin
								cmd_d   = in_byte;
								pos_d   = 3'd0;
								ok_d    = 1'b0;
								prev_d  = SB;
								phase_d = PH_SUB;
							end
						end
						PH_OPT: begin
							job_valid = 1'b1;
							job.kind  = JOB_ANSWER;
							phase_d   = PH_IDLE;
						end
						default: begin
							if (pos_q == 3'd0) opt_d = in_byte;
							if (pos_q == 3'd1) ok_d = (in_byte == 8'd1);
							if (prev_q == IAC && in_byte == SE) begin
								phase_d = PH_IDLE;
								if (pos_q == 3'd3 && ok_q && (opt_q == OPT_TTYPE ||
									opt_q == OPT_SPEED || opt_q == OPT_ENV)) begin
									job_valid = 1'b1;
									job.kind  = JOB_SUB;
									job.b0    = opt_q;
								end
							end else begin
								if (pos_q != 3'd7) pos_d = pos_q + 3'd1;
								prev_d = in_byte;
							end
						end
					endcase
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cmd_q   <= 8'd0;
			opt_q   <= 8'd0;
			pos_q   <= 3'd0;
			prev_q  <= 8'd0;
			ok_q    <= 1'b0;
		end else begin
			phase_q <= phase_d;
			cmd_q   <= cmd_d;
			opt_q   <= opt_d;
			pos_q   <= pos_d;
			prev_q  <= prev_d;
			ok_q    <= ok_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && mode == MODE_RX && phase_q == PH_IDLE && in_byte == IAC)
		|=> phase_q == PH_CMD)
		else $error("IAC did not enter command phase");
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_OPT) |-> (cmd_q >= WILL))
		else $error("option phase without negotiation command");
	assert property (@(posedge clk) disable iff (!arst_n)
		(job_valid && job.kind == JOB_SUB) |-> (pos_q == 3'd3 && ok_q))
		else $error("subnegotiation reply from wrong form");

endmodule

// ===== rtl/core/tno_back.sv =====
// ----------------------------------------------------------------------------
// Telnet option negotiator back end
// Job queue and byte emitter that expands each job into result bytes.
// ----------------------------------------------------------------------------
module tno_back import tno_pkg::*; #(
	parameter int NAME_BYTES = 16,
	parameter int QDEPTH     = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	input  job_t                job,
	output logic                q_full,
	input  logic [8*16-1:0]     name_bytes,
	input  logic [4:0]          name_len,
	output logic                empty,
	input  logic                pop,
	output logic                to_link,
	output logic [7:0]          out_byte,
	output logic                last
);

	localparam int QW = $clog2(QDEPTH);

	job_t            mem_q [QDEPTH];
	logic [QW-1:0]   wp_q;
	logic [QW-1:0]   rp_q;
	logic [QW:0]     cnt_q;

	logic            busy_q;
	job_t            cur_q;
	emit_phase_t     ep_q;
	logic [4:0]      idx_q;
	logic            dup_q;

	logic            obuf_v_q;
	logic            obuf_link_q;
	logic [7:0]      obuf_byte_q;
	logic            obuf_last_q;

	logic            take;
	logic            gen;
	logic            gen_link;
	logic [7:0]      gen_byte;
	logic            gen_last;
	logic            advance;
	logic [4:0]      len_sat;
	logic [7:0]      nb;
	logic [7:0]      naws_b;
	logic            skip_name;

	assign q_full = (cnt_q == QDEPTH[QW:0]);
	assign advance = !obuf_v_q || pop;
	assign len_sat = (name_len > NAME_BYTES[4:0]) ? NAME_BYTES[4:0] : name_len;
	assign nb = name_bytes[idx_q[3:0]*8 +: 8];
	assign naws_b = cur_q.wh[(3 - idx_q[1:0])*8 +: 8];

	always_comb begin
		gen       = 1'b0;
		gen_link  = 1'b1;
		gen_byte  = 8'd0;
		gen_last  = 1'b0;
		skip_name = 1'b0;
		if (busy_q) begin
			case (ep_q)
				EP_HEAD: begin
					gen = 1'b1;
					case (cur_q.kind)
						JOB_APP: begin
							gen_link = 1'b0;
							gen_byte = cur_q.b0;
							gen_last = 1'b1;
						end
						JOB_LINK: begin
							gen_byte = cur_q.b0;
							gen_last = (cur_q.b0 != IAC) || dup_q;
						end
						JOB_ANSWER: begin
							case (idx_q[1:0])
								2'd0: gen_byte = IAC;
								2'd1: begin
									if (cur_q.b1 == WILL)
										gen_byte = (cur_q.b0 == 8'd1 || cur_q.b0 == 8'd3)
											? DO : DONT;
									else if (cur_q.b1 == WONT)
										gen_byte = DONT;
									else if (cur_q.b1 == DO)
										gen_byte = (cur_q.b0 == 8'd1 || cur_q.b0 == 8'd3 ||
											cur_q.b0 == OPT_TTYPE || cur_q.b0 == OPT_NAWS)
											? WILL : WONT;
									else
										gen_byte = WONT;
								end
								default: begin
									gen_byte = cur_q.b0;
									gen_last = 1'b1;
								end
							endcase
						end
						JOB_SUB: begin
							case (idx_q[1:0])
								2'd0: gen_byte = IAC;
								2'd1: gen_byte = SB;
								2'd2: gen_byte = cur_q.b0;
								default: gen_byte = 8'd0;
							endcase
						end
						default: begin
							case (idx_q[1:0])
								2'd0: gen_byte = IAC;
								2'd1: gen_byte = SB;
								default: gen_byte = OPT_NAWS;
							endcase
						end
					endcase
				end
				EP_NAME: begin
					if (idx_q < len_sat) begin
						skip_name = !(nb >= 8'd32 && nb <= 8'd126);
						gen       = !skip_name;
						gen_byte  = nb;
					end
				end
				EP_SPEED: begin
					gen      = 1'b1;
					gen_byte = speed_byte(idx_q[3:0]);
				end
				EP_NAWS: begin
					gen      = 1'b1;
					gen_byte = naws_b;
				end
				default: begin
					gen      = 1'b1;
					gen_byte = (idx_q[0]) ? SE : IAC;
					gen_last = idx_q[0];
				end
			endcase
		end
	end

	assign take = (!busy_q || (advance && gen && gen_last)) && (cnt_q != '0);

	always_ff @(posedge clk) begin
		if (job_valid && !q_full) mem_q[wp_q] <= job;
		if (take) cur_q <= mem_q[rp_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			rp_q     <= '0;
			cnt_q    <= '0;
			busy_q   <= 1'b0;
			ep_q     <= EP_HEAD;
			idx_q    <= 5'd0;
			dup_q    <= 1'b0;
			obuf_v_q <= 1'b0;
		end else begin
			if (job_valid && !q_full) wp_q <= (wp_q == QW'(QDEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (take) rp_q <= (rp_q == QW'(QDEPTH - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + {{QW{1'b0}}, (job_valid && !q_full)} - {{QW{1'b0}}, take};

			if (advance) obuf_v_q <= gen;

			if (take) begin
				busy_q <= 1'b1;
				ep_q   <= EP_HEAD;
				idx_q  <= 5'd0;
				dup_q  <= 1'b0;
			end else if (busy_q && (advance || !gen)) begin
				if (gen && gen_last) begin
					busy_q <= 1'b0;
				end else begin
					case (ep_q)
						EP_HEAD: begin
							if (cur_q.kind == JOB_LINK) begin
								dup_q <= 1'b1;
							end else if (cur_q.kind == JOB_SUB && idx_q == 5'd3) begin
								idx_q <= 5'd0;
								ep_q  <= (cur_q.b0 == OPT_TTYPE) ? EP_NAME :
									(cur_q.b0 == OPT_SPEED) ? EP_SPEED : EP_TAIL;
							end else if (cur_q.kind == JOB_NAWS && idx_q == 5'd2) begin
								idx_q <= 5'd0;
								ep_q  <= EP_NAWS;
							end else begin
								idx_q <= idx_q + 5'd1;
							end
						end
						EP_NAME: begin
							if (idx_q >= len_sat) begin
								idx_q <= 5'd0;
								ep_q  <= EP_TAIL;
							end else begin
								idx_q <= idx_q + 5'd1;
							end
						end
						EP_SPEED: begin
							if (idx_q == 5'(SPEED_LEN - 1)) begin
								idx_q <= 5'd0;
								ep_q  <= EP_TAIL;
							end else begin
								idx_q <= idx_q + 5'd1;
							end
						end
						EP_NAWS: begin
							if (naws_b == IAC && !dup_q) begin
								dup_q <= 1'b1;
							end else begin
								dup_q <= 1'b0;
								if (idx_q == 5'd3) begin
									idx_q <= 5'd0;
									ep_q  <= EP_TAIL;
								end else begin
									idx_q <= idx_q + 5'd1;
								end
							end
						end
						default: idx_q <= idx_q + 5'd1;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			obuf_link_q <= gen_link;
			obuf_byte_q <= gen_byte;
			obuf_last_q <= gen_last;
		end
	end

	assign empty    = !obuf_v_q;
	assign to_link  = obuf_link_q;
	assign out_byte = obuf_byte_q;
	assign last     = obuf_last_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QDEPTH[QW:0])
		else $error("job queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(obuf_v_q && !pop) |=> (obuf_v_q && $stable(obuf_byte_q)))
		else $error("waiting result changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		(obuf_v_q && !obuf_link_q) |-> obuf_last_q)
		else $error("application byte not final");

endmodule

// ===== rtl/core/telnet_option_negotiator.sv =====
// A request passes through the job queue, the current-job register and the output register before its first result.
// Throughput: one request per cycle while full is low; replies drain at up to one byte
// per cycle from the emitter while pop is held, and a four-entry job queue absorbs bursts.
// A job occupies the emitter until its last result byte has been generated.
// Reset: arst_n clears parser state, job queue and output; name registers read 0.
// ----------------------------------------------------------------------------
// Telnet option negotiator top level
// Configuration port, request front end and reply back end.
// ----------------------------------------------------------------------------
module telnet_option_negotiator import tno_pkg::*; #(
	parameter int NAME_BYTES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  mode,
	input  logic [7:0]  in_byte,
	input  logic [15:0] window_width,
	input  logic [15:0] window_height,
	output logic        empty,
	input  logic        pop,
	output logic        to_link,
	output logic [7:0]  out_byte,
	output logic        last
);

	localparam logic [1:0] REG_FIRST = 2'd0;
	localparam logic [1:0] REG_LAST  = 2'd1;
	localparam logic [1:0] REG_LEN   = 2'd2;

	logic [63:0] first_q;
	logic [63:0] last_bytes_q;
	logic [4:0]  len_q;
	logic        wr;
	logic        job_valid;
	job_t        job;
	logic        q_full;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q      <= 64'd0;
			last_bytes_q <= 64'd0;
			len_q        <= 5'd0;
		end else if (wr && paddr[2:0] == 3'd0) begin
			case (paddr[4:3])
				REG_FIRST: first_q      <= pwdata;
				REG_LAST:  last_bytes_q <= pwdata;
				REG_LEN:   len_q        <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:3])
			REG_FIRST: prdata = first_q;
			REG_LAST:  prdata = last_bytes_q;
			REG_LEN:   prdata = {59'd0, len_q};
			default:   prdata = 64'd0;
		endcase
	end

	assign full = q_full;

	tno_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (push && !q_full),
		.mode          (mode),
		.in_byte       (in_byte),
		.window_width  (window_width),
		.window_height (window_height),
		.job_valid     (job_valid),
		.job           (job)
	);

	tno_back #(
		.NAME_BYTES (NAME_BYTES),
		.QDEPTH     (4)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (job_valid),
		.job        (job),
		.q_full     (q_full),
		.name_bytes ({last_bytes_q, first_q}),
		.name_len   (len_q),
		.empty      (empty),
		.pop        (pop),
		.to_link    (to_link),
		.out_byte   (out_byte),
		.last       (last)
	);

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Telnet option negotiator testbench
// Drives link bytes, outbound bytes and window size requests through the
// request queue and reprograms the terminal name between phases. Every reply
// byte is checked against a behavioral predictor kept in this module.
// ----------------------------------------------------------------------------
module tb_top;
	import tno_pkg::*;

	localparam logic [4:0] ADDR_NAME_LO  = 5'd0;
	localparam logic [4:0] ADDR_NAME_HI  = 5'd8;
	localparam logic [4:0] ADDR_NAME_LEN = 5'd16;
	localparam logic [1:0] MODE_NONE     = 2'd3;
	localparam int         CYCLE_LIMIT   = 400000;
	localparam int         SETTLE_CYCLES = 12;

	typedef struct packed {
		logic       to_link;
		logic [7:0] out_byte;
		logic       last;
	} reply_t;

	typedef struct packed {
		logic [1:0]  m;
		logic [7:0]  b;
		logic [15:0] w;
		logic [15:0] h;
		logic        typed;
		logic        t_link;
		logic [7:0]  t_byte;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [4:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;
	logic        push, full;
	logic [1:0]  mode;
	logic [7:0]  in_byte;
	logic [15:0] window_width, window_height;
	logic        empty, pop;
	logic        to_link;
	logic [7:0]  out_byte;
	logic        last;

	reply_t   expected_q[$];
	reply_t   pending_q[$];
	dir_row_t dir_tab[$];

	logic [63:0] name_lo, name_hi;
	logic [4:0]  name_len;
	phase_t      prs_phase;
	logic [7:0]  prs_cmd, prs_opt, prs_prev;
	logic [2:0]  prs_pos;
	logic        prs_send_ok;

	int cycles, errors, requests, replies_seen, burst_left;

	telnet_option_negotiator i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.push(push), .full(full), .mode(mode), .in_byte(in_byte),
		.window_width(window_width), .window_height(window_height),
		.empty(empty), .pop(pop), .to_link(to_link), .out_byte(out_byte),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// The receiver steps through four stall behaviors in turn as the cycle counter advances.
	always @(negedge clk) begin
		case ((cycles / 300) % 4)
			0: pop <= 1'b1;
			1: pop <= 1'($urandom_range(0, 1));
			2: pop <= ($urandom_range(0, 3) == 0);
			default: pop <= ($urandom_range(0, 7) != 0);
		endcase
	end

	always @(posedge clk) begin
		reply_t want;
		if (arst_n && pop && !empty) begin
			replies_seen++;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected reply link=%0d byte=%02h last=%0d",
					$time, to_link, out_byte, last);
				errors++;
			end else begin
				want = expected_q.pop_front();
				if (want.to_link !== to_link)
					$display("%0t: to_link expected %0d actual %0d", $time,
						want.to_link, to_link);
				if (want.out_byte !== out_byte)
					$display("%0t: out_byte expected %02h actual %02h", $time,
						want.out_byte, out_byte);
				if (want.last !== last)
					$display("%0t: last expected %0d actual %0d", $time,
						want.last, last);
				if (want.to_link !== to_link || want.out_byte !== out_byte ||
						want.last !== last)
					errors++;
			end
		end
	end

	task automatic add_byte(input logic link, input logic [7:0] b);
		if (pending_q.size() < 22)
			pending_q.push_back('{to_link: link, out_byte: b, last: 1'b0});
	endtask

	task automatic add_escaped(input logic [7:0] b);
		add_byte(1'b1, b);
		if (b == IAC)
			add_byte(1'b1, IAC);
	endtask

	task automatic add_sub_reply(input logic [7:0] opt);
		int         n;
		logic [7:0] c;
		string      spd;
		spd = "38400,38400";
		add_byte(1'b1, IAC);
		add_byte(1'b1, SB);
		add_byte(1'b1, opt);
		add_byte(1'b1, 8'd0);
		if (opt == OPT_TTYPE) begin
			n = (name_len > 16) ? 16 : name_len;
			for (int i = 0; i < n; i++) begin
				c = (i < 8) ? name_lo[i*8 +: 8] : name_hi[(i-8)*8 +: 8];
				if (c >= 8'd32 && c <= 8'd126)
					add_byte(1'b1, c);
			end
		end else if (opt == OPT_SPEED) begin
			for (int i = 0; i < spd.len(); i++)
				add_byte(1'b1, spd[i]);
		end
		add_byte(1'b1, IAC);
		add_byte(1'b1, SE);
	endtask

	task automatic parse_link_byte(input logic [7:0] b);
		logic [7:0] r;
		case (prs_phase)
			PH_IDLE: begin
				if (b == IAC)
					prs_phase = PH_CMD;
				else
					add_byte(1'b0, b);
			end
			PH_CMD: begin
				if (b == IAC) begin
					add_byte(1'b0, IAC);
					prs_phase = PH_IDLE;
				end else if (b >= WILL) begin
					prs_cmd = b;
					prs_phase = PH_OPT;
				end else if (b == SB) begin
					prs_cmd = b;
					prs_pos = 3'd0;
					prs_send_ok = 1'b0;
					prs_prev = SB;
					prs_phase = PH_SUB;
				end else begin
					prs_phase = PH_IDLE;
				end
			end
			PH_OPT: begin
				if (prs_cmd == WILL)
					r = (b == 8'd1 || b == 8'd3) ? DO : DONT;
				else if (prs_cmd == WONT)
					r = DONT;
				else if (prs_cmd == DO)
					r = (b == 8'd1 || b == 8'd3 || b == OPT_TTYPE || b == OPT_NAWS) ?
						WILL : WONT;
				else
					r = WONT;
				add_byte(1'b1, IAC);
				add_byte(1'b1, r);
				add_byte(1'b1, b);
				prs_phase = PH_IDLE;
			end
			default: begin
				if (prs_pos == 3'd0)
					prs_opt = b;
				if (prs_pos == 3'd1)
					prs_send_ok = (b == 8'd1);
				if (prs_prev == IAC && b == SE) begin
					if (prs_pos == 3'd3 && prs_send_ok && (prs_opt == OPT_TTYPE ||
							prs_opt == OPT_SPEED || prs_opt == OPT_ENV))
						add_sub_reply(prs_opt);
					prs_phase = PH_IDLE;
				end else begin
					if (prs_pos < 3'd7)
						prs_pos++;
					prs_prev = b;
				end
			end
		endcase
	endtask

	task automatic predict_replies(input logic [1:0] m, input logic [7:0] b,
			input logic [15:0] w, input logic [15:0] h);
		pending_q.delete();
		if (m == MODE_RX) begin
			parse_link_byte(b);
		end else if (m == MODE_TX) begin
			add_escaped(b);
		end else if (m == MODE_NAWS) begin
			add_byte(1'b1, IAC);
			add_byte(1'b1, SB);
			add_byte(1'b1, OPT_NAWS);
			add_escaped(w[15:8]);
			add_escaped(w[7:0]);
			add_escaped(h[15:8]);
			add_escaped(h[7:0]);
			add_byte(1'b1, IAC);
			add_byte(1'b1, SE);
		end
		if (pending_q.size() > 0)
			pending_q[pending_q.size()-1].last = 1'b1;
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_request(input logic [1:0] m, input logic [7:0] b,
			input logic [15:0] w, input logic [15:0] h);
		int gap;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		push <= 1'b1;
		mode <= m;
		in_byte <= b;
		window_width <= w;
		window_height <= h;
		#1;
		while (full) @(negedge clk);
		@(posedge clk);
		predict_replies(m, b, w, h);
		foreach (pending_q[i])
			expected_q.push_back(pending_q[i]);
		if (m != MODE_NONE)
			requests++;
		burst_left--;
		@(negedge clk);
	endtask

	task automatic reg_write(input logic [4:0] addr, input logic [63:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (addr)
			ADDR_NAME_LO:  name_lo = data;
			ADDR_NAME_HI:  name_hi = data;
			ADDR_NAME_LEN: name_len = data[4:0];
			default: ;
		endcase
	endtask

	task automatic drain_and_settle();
		push <= 1'b0;
		burst_left = 0;
		while (expected_q.size() > 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_name(input logic [63:0] lo, input logic [63:0] hi,
			input logic [4:0] len);
		reg_write(ADDR_NAME_LO, lo);
		reg_write(ADDR_NAME_HI, hi);
		reg_write(ADDR_NAME_LEN, {59'd0, len});
	endtask

	function automatic logic [7:0] any_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_rx(input logic [7:0] b);
		send_request(MODE_RX, b, 16'd0, 16'd0);
	endtask

	// One random protocol sequence; most are well formed with random content.
	task automatic random_sequence();
		int          pick, n;
		logic [7:0]  opt, b;
		logic [15:0] w, h;
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			send_rx(8'($urandom_range(0, 254)));
		end else if (pick < 40) begin
			send_rx(IAC);
			send_rx(8'($urandom_range(WILL, DONT)));
			case ($urandom_range(0, 4))
				0: opt = 8'd1;
				1: opt = 8'd3;
				2: opt = OPT_TTYPE;
				3: opt = OPT_NAWS;
				default: opt = any_byte();
			endcase
			send_rx(opt);
		end else if (pick < 55) begin
			case ($urandom_range(0, 4))
				0, 1: opt = OPT_TTYPE;
				2: opt = OPT_SPEED;
				3: opt = OPT_ENV;
				default: opt = any_byte();
			endcase
			send_rx(IAC);
			send_rx(SB);
			send_rx(opt);
			send_rx(($urandom_range(0, 5) == 0) ? any_byte() : 8'd1);
			if ($urandom_range(0, 7) == 0)
				send_rx(8'($urandom_range(0, 254)));
			send_rx(IAC);
			send_rx(SE);
		end else if (pick < 62) begin
			send_rx(IAC);
			send_rx(SB);
			n = $urandom_range(0, 9);
			for (int i = 0; i < n; i++) begin
				b = any_byte();
				if (b == IAC)
					send_rx(IAC);
				else if (b != SE)
					send_rx(b);
			end
			send_rx(IAC);
			send_rx(SE);
		end else if (pick < 67) begin
			send_rx(IAC);
			case ($urandom_range(0, 2))
				0: send_rx(IAC);
				1: send_rx(GA);
				default: send_rx(8'($urandom_range(0, 249)));
			endcase
		end else if (pick < 80) begin
			send_request(MODE_TX, ($urandom_range(0, 3) == 0) ? IAC : any_byte(),
				16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
		end else if (pick < 88) begin
			w = 16'($urandom_range(0, 65535));
			h = 16'($urandom_range(0, 65535));
			if ($urandom_range(0, 2) == 0) w[7:0] = 8'hFF;
			if ($urandom_range(0, 2) == 0) h[15:8] = 8'hFF;
			send_request(MODE_NAWS, any_byte(), w, h);
		end else if (pick < 92) begin
			send_request(MODE_NONE, any_byte(), 16'($urandom_range(0, 65535)),
				16'($urandom_range(0, 65535)));
		end else begin
			send_rx(any_byte());
		end
	endtask

	task automatic random_phase(input int count, input bit hold_once);
		int start_cnt;
		bit held;
		start_cnt = requests;
		held = 1'b0;
		while (requests - start_cnt < count) begin
			random_sequence();
			if (hold_once && !held && requests - start_cnt > count / 2) begin
				push <= 1'b0;
				burst_left = 0;
				@(negedge clk);
				while (expected_q.size() > 0) @(negedge clk);
				held = 1'b1;
			end
		end
		drain_and_settle();
	endtask

	initial begin
		dir_row_t row;
		logic [63:0] lo, hi;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		push = 1'b0;
		pop = 1'b0;
		mode = MODE_RX;
		in_byte = '0;
		window_width = '0;
		window_height = '0;
		cycles = 0;
		errors = 0;
		requests = 0;
		replies_seen = 0;
		burst_left = 0;
		name_lo = '0;
		name_hi = '0;
		name_len = '0;
		prs_phase = PH_IDLE;
		prs_cmd = '0;
		prs_opt = '0;
		prs_prev = '0;
		prs_pos = '0;
		prs_send_ok = 1'b0;

		dir_tab.push_back({MODE_RX, 8'h00, 16'd0, 16'd0, 1'b1, 1'b0, 8'h00});
		dir_tab.push_back({MODE_RX, 8'hFE, 16'd0, 16'd0, 1'b1, 1'b0, 8'hFE});
		dir_tab.push_back({MODE_RX, IAC, 16'd0, 16'd0, 1'b0, 1'b0, 8'h00});
		dir_tab.push_back({MODE_RX, IAC, 16'd0, 16'd0, 1'b1, 1'b0, IAC});
		dir_tab.push_back({MODE_RX, IAC, 16'd0, 16'd0, 1'b0, 1'b0, 8'h00});
		dir_tab.push_back({MODE_RX, GA, 16'd0, 16'd0, 1'b0, 1'b0, 8'h00});
		dir_tab.push_back({MODE_RX, IAC, 16'd0, 16'd0, 1'b0, 1'b0, 8'h00});
		dir_tab.push_back({MODE_RX, WILL, 16'd0, 16'd0, 1'b0, 1'b0, 8'h00});
		dir_tab.push_back({MODE_RX, 8'd1, 16'd0, 16'd0, 1'b0, 1'b0, 8'h00});
		dir_tab.push_back({MODE_RX, IAC, 16'd0, 16'd0, 1'b0, 1'b0, 8'h00});
		dir_tab.push_back({MODE_RX, DO, 16'd0, 16'd0, 1'b0, 1'b0, 8'h00});
		dir_tab.push_back({MODE_RX, 8'd99, 16'd0, 16'd0, 1'b0, 1'b0, 8'h00});
		dir_tab.push_back({MODE_RX, IAC, 16'd0, 16'd0, 1'b0, 1'b0, 8'h00});
		dir_tab.push_back({MODE_RX, DONT, 16'd0, 16'd0, 1'b0, 1'b0, 8'h00});
		dir_tab.push_back({MODE_RX, OPT_TTYPE, 16'd0, 16'd0, 1'b0, 1'b0, 8'h00});
		dir_tab.push_back({MODE_RX, IAC, 16'd0, 16'd0, 1'b0, 1'b0, 8'h00});
		dir_tab.push_back({MODE_RX, 8'd241, 16'd0, 16'd0, 1'b0, 1'b0, 8'h00});
		dir_tab.push_back({MODE_RX, IAC, 16'd0, 16'd0, 1'b0, 1'b0, 8'h00});
		dir_tab.push_back({MODE_RX, SB, 16'd0, 16'd0, 1'b0, 1'b0, 8'h00});
		dir_tab.push_back({MODE_RX, OPT_TTYPE, 16'd0, 16'd0, 1'b0, 1'b0, 8'h00});
		dir_tab.push_back({MODE_RX, 8'd1, 16'd0, 16'd0, 1'b0, 1'b0, 8'h00});
		dir_tab.push_back({MODE_RX, IAC, 16'd0, 16'd0, 1'b0, 1'b0, 8'h00});
		dir_tab.push_back({MODE_RX, SE, 16'd0, 16'd0, 1'b0, 1'b0, 8'h00});
		dir_tab.push_back({MODE_TX, 8'h00, 16'd0, 16'd0, 1'b1, 1'b1, 8'h00});
		dir_tab.push_back({MODE_TX, IAC, 16'd0, 16'd0, 1'b0, 1'b0, 8'h00});
		dir_tab.push_back({MODE_NAWS, 8'h00, 16'hFFFF, 16'h00FF, 1'b0, 1'b0, 8'h00});
		dir_tab.push_back({MODE_NAWS, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0, 8'h00});
		dir_tab.push_back({MODE_NONE, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 8'h00});

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// A name with control bytes mixed in, and more control bytes past the length.
		set_name(64'h3130_3174_0A76_7407, 64'h0000_0000_0000_4142, 5'd9);
		foreach (dir_tab[i]) begin
			row = dir_tab[i];
			send_request(row.m, row.b, row.w, row.h);
			if (row.typed && (pending_q.size() != 1 || pending_q[0].to_link !== row.t_link ||
					pending_q[0].out_byte !== row.t_byte || pending_q[0].last !== 1'b1)) begin
				$display("%0t: row %0d expected link=%0d byte=%02h, predicted other",
					$time, i, row.t_link, row.t_byte);
				errors++;
			end
		end
		drain_and_settle();

		set_name('1, '1, 5'd31);
		random_phase(110, 1'b0);
		lo = {$urandom(), $urandom()} & 64'h3F3F_3F3F_3F3F_3F3F | 64'h4040_4040_4040_4040;
		hi = {$urandom(), $urandom()} & 64'h3F3F_3F3F_3F3F_3F3F | 64'h2020_2020_2020_2020;
		set_name(lo, hi, 5'd16);
		random_phase(110, 1'b1);
		set_name('0, '0, 5'd0);
		random_phase(100, 1'b0);
		set_name({$urandom(), $urandom()}, {$urandom(), $urandom()},
			5'($urandom_range(0, 31)));
		random_phase(110, 1'b0);

		$display("Covered %0d requests and %0d reply bytes over five name settings,",
			requests, replies_seen);
		$display("with burst gaps on the request side and varied stalls on replies.");
		if (errors == 0 && expected_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches, %0d replies missing", errors, expected_q.size());
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
